// ===== hw/rtl/bfsp_pkg.sv =====
// Shared types and field widths for the Bellman-Ford shortest path core.
`default_nettype none
package bfsp_pkg;

    localparam int VIDX_W      = 4;
    localparam int WEIGHT_IN_W = 16;
    localparam int DIST_OUT_W  = 24;
    localparam int CFG_W       = 5;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;

    typedef struct packed {
        logic reached_u;
        logic reached_v;
    } relax_in_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bfsp_weight_ram.sv =====
// Weight matrix memory: one write port, one registered read port.
`default_nettype none
module bfsp_weight_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int W     = 16
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [W-1:0]  wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bfsp_relax_unit.sv =====
// Shared relaxation unit: saturating distance plus weight and improvement compare.
`default_nettype none
module bfsp_relax_unit #(
    parameter int WEIGHT_BITS = 16,
    parameter int DIST_BITS   = 24
) (
    input  wire logic signed [DIST_BITS-1:0]   dist_u,
    input  wire logic signed [WEIGHT_BITS-1:0] weight,
    input  wire logic signed [DIST_BITS-1:0]   dist_v,
    input  wire bfsp_pkg::relax_in_t            flags,
    output logic signed      [DIST_BITS-1:0]   cand,
    output logic                                improve
);
    import bfsp_pkg::*;

    localparam int SW = (DIST_BITS > WEIGHT_BITS ? DIST_BITS : WEIGHT_BITS) + 1;
    localparam logic signed [DIST_BITS-1:0] DMAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic signed [DIST_BITS-1:0] DMIN = {1'b1, {(DIST_BITS-1){1'b0}}};

    logic signed [SW-1:0] sum;

    always_comb
    begin
        sum = SW'(dist_u) + SW'(weight);
        if (sum > SW'(DMAX))
        begin
            cand = DMAX;
        end
        else if (sum < SW'(DMIN))
        begin
            cand = DMIN;
        end
        else
        begin
            cand = DIST_BITS'(sum);
        end
        improve = (weight != '0) && flags.reached_u && (!flags.reached_v || (cand < dist_v));
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bellman_ford_shortest_path_core.sv =====
// Top level of the Bellman-Ford shortest path core: sequencer, distance store, stream ports.
`default_nettype none
// A weight write (tuser = 0) is accepted back to back while idle. A run (tuser = 1)
// holds s_axis_tready low while one shared relaxation unit walks every (u,v) pair of
// the n-by-n matrix: a setup state, then n passes (n-1 relaxing plus one negative-cycle
// check that stops at the first relaxable edge); in each pass every row reloads dist[u]
// and every edge takes a memory read state and a relax state. Results then come out one
// at a time, each read, loaded and held until the downstream accepts it; a negative cycle
// gives a single result with tuser = 1. n is vertex_count clamped to 1..MAX_VERTICES.
// Every matrix entry in use must be written before a run.
module bellman_ford_shortest_path_core #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16,
    parameter int DIST_BITS    = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bfsp_pkg::CFG_W-1:0]      cfg_wr_data,   // vertex_count
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // row_vertex[3:0], col_vertex[7:4], edge_weight[23:8], source_vertex[27:24]
    input  wire logic [bfsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tuser,  // mode
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // vertex_index[3:0], distance[27:4], reachable[28]
    output logic [bfsp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tuser,  // negative_cycle
    output logic                                 m_axis_tlast   // last
);
    import bfsp_pkg::*;

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int WX = (WEIGHT_BITS > WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
    localparam int DX = (DIST_BITS > DIST_OUT_W) ? DIST_BITS : DIST_OUT_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_ROW_RD   = 4'd2;
    localparam logic [3:0] ST_ROW_LD   = 4'd3;
    localparam logic [3:0] ST_EDGE_RD  = 4'd4;
    localparam logic [3:0] ST_EDGE_EX  = 4'd5;
    localparam logic [3:0] ST_OUT_RD   = 4'd6;
    localparam logic [3:0] ST_OUT_LD   = 4'd7;
    localparam logic [3:0] ST_OUT_WAIT = 4'd8;
    localparam logic [3:0] ST_NEG_WAIT = 4'd9;

    logic [3:0]                    state_reg;
    logic [CFG_W-1:0]              vertex_count_reg;
    logic [CW-1:0]                 n_reg;
    logic [IW-1:0]                 u_reg;
    logic [IW-1:0]                 v_reg;
    logic [IW-1:0]                 pass_reg;
    logic [IW-1:0]                 out_idx_reg;
    logic [IW-1:0]                 src_reg;
    logic                          src_ok_reg;
    logic [MAX_VERTICES-1:0]       reached_reg;
    logic signed [DIST_BITS-1:0]   dist_u_reg;
    logic                          reached_u_reg;

    logic                          m_tvalid_reg;
    logic [OUT_DATA_W-1:0]         m_tdata_reg;
    logic                          m_tuser_reg;
    logic                          m_tlast_reg;

    logic signed [DIST_BITS-1:0]   dist_mem [MAX_VERTICES];
    logic signed [DIST_BITS-1:0]   dist_rd_reg;
    logic                          dist_we;
    logic [IW-1:0]                 dist_waddr;
    logic signed [DIST_BITS-1:0]   dist_wdata;
    logic [IW-1:0]                 dist_raddr;

    logic [VIDX_W-1:0]             in_row;
    logic [VIDX_W-1:0]             in_col;
    logic signed [WEIGHT_IN_W-1:0] in_weight;
    logic [VIDX_W-1:0]             in_src;
    logic                          in_accept;
    logic                          wgt_we;
    logic [AW-1:0]                 wgt_waddr;
    logic [WEIGHT_BITS-1:0]        wgt_wdata;
    logic [AW-1:0]                 wgt_raddr;
    logic [WEIGHT_BITS-1:0]        wgt_rdata;

    logic [CW-1:0]                 n_calc;
    logic                          src_ok_calc;
    relax_in_t                     relax_flags;
    logic signed [DIST_BITS-1:0]   cand;
    logic                          improve;
    logic                          v_last;
    logic                          u_last;
    logic                          check_pass;
    logic                          out_last;
    logic [DIST_OUT_W-1:0]         dist_out;

    assign in_row    = s_axis_tdata[3:0];
    assign in_col    = s_axis_tdata[7:4];
    assign in_weight = s_axis_tdata[23:8];
    assign in_src    = s_axis_tdata[27:24];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            n_calc = CW'(1);
        end
        else if (int'(vertex_count_reg) > MAX_VERTICES)
        begin
            n_calc = CW'(MAX_VERTICES);
        end
        else
        begin
            n_calc = CW'(vertex_count_reg);
        end
        src_ok_calc = int'(in_src) < int'(n_calc);
    end

    assign wgt_we    = in_accept && !s_axis_tuser && (int'(in_row) < MAX_VERTICES)
                       && (int'(in_col) < MAX_VERTICES);
    assign wgt_waddr = AW'(in_row) * AW'(MAX_VERTICES) + AW'(in_col);
    assign wgt_wdata = WEIGHT_BITS'(WX'(in_weight));
    assign wgt_raddr = AW'(u_reg) * AW'(MAX_VERTICES) + AW'(v_reg);

    bfsp_weight_ram #(
        .DEPTH (MAX_VERTICES * MAX_VERTICES),
        .AW    (AW),
        .W     (WEIGHT_BITS)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (wgt_we),
        .wr_addr (wgt_waddr),
        .wr_data (wgt_wdata),
        .rd_addr (wgt_raddr),
        .rd_data (wgt_rdata)
    );

    assign relax_flags.reached_u = reached_u_reg;
    assign relax_flags.reached_v = reached_reg[v_reg];

    bfsp_relax_unit #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .DIST_BITS   (DIST_BITS)
    ) u_relax_unit (
        .dist_u  (dist_u_reg),
        .weight  (signed'(wgt_rdata)),
        .dist_v  (dist_rd_reg),
        .flags   (relax_flags),
        .cand    (cand),
        .improve (improve)
    );

    assign v_last     = (CW'(v_reg) + CW'(1)) == n_reg;
    assign u_last     = (CW'(u_reg) + CW'(1)) == n_reg;
    assign check_pass = (CW'(pass_reg) + CW'(1)) == n_reg;
    assign out_last   = (CW'(out_idx_reg) + CW'(1)) == n_reg;
    assign dist_out   = DIST_OUT_W'(DX'(dist_rd_reg));

    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = v_reg;
        dist_wdata = cand;
        case (state_reg)
            ST_START:
            begin
                dist_we    = src_ok_reg;
                dist_waddr = src_reg;
                dist_wdata = '0;
            end
            ST_EDGE_EX:
            begin
                dist_we = improve && !check_pass;
            end
            default:
            begin
                dist_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_ROW_RD: dist_raddr = u_reg;
            ST_OUT_RD: dist_raddr = out_idx_reg;
            default:   dist_raddr = v_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd_reg <= dist_mem[dist_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= CFG_W'(16);
            n_reg            <= '0;
            u_reg            <= '0;
            v_reg            <= '0;
            pass_reg         <= '0;
            out_idx_reg      <= '0;
            src_reg          <= '0;
            src_ok_reg       <= 1'b0;
            reached_reg      <= '0;
            reached_u_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vertex_count_reg <= cfg_wr_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && s_axis_tuser)
                    begin
                        n_reg       <= n_calc;
                        src_reg     <= IW'(in_src);
                        src_ok_reg  <= src_ok_calc;
                        reached_reg <= src_ok_calc ? (MAX_VERTICES'(1) << in_src) : '0;
                        state_reg   <= ST_START;
                    end
                end
                ST_START:
                begin
                    u_reg     <= '0;
                    v_reg     <= '0;
                    pass_reg  <= '0;
                    state_reg <= ST_ROW_RD;
                end
                ST_ROW_RD:
                begin
                    state_reg <= ST_ROW_LD;
                end
                ST_ROW_LD:
                begin
                    dist_u_reg    <= dist_rd_reg;
                    reached_u_reg <= reached_reg[u_reg];
                    state_reg     <= ST_EDGE_RD;
                end
                ST_EDGE_RD:
                begin
                    state_reg <= ST_EDGE_EX;
                end
                ST_EDGE_EX:
                begin
                    if (improve && check_pass)
                    begin
                        m_tdata_reg  <= '0;
                        m_tuser_reg  <= 1'b1;
                        m_tlast_reg  <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_NEG_WAIT;
                    end
                    else
                    begin
                        if (improve)
                        begin
                            reached_reg[v_reg] <= 1'b1;
                            if (v_reg == u_reg)
                            begin
                                dist_u_reg <= cand;
                            end
                        end
                        if (!v_last)
                        begin
                            v_reg     <= v_reg + IW'(1);
                            state_reg <= ST_EDGE_RD;
                        end
                        else
                        begin
                            v_reg <= '0;
                            if (!u_last)
                            begin
                                u_reg     <= u_reg + IW'(1);
                                state_reg <= ST_ROW_RD;
                            end
                            else
                            begin
                                u_reg <= '0;
                                if (check_pass)
                                begin
                                    out_idx_reg <= '0;
                                    state_reg   <= ST_OUT_RD;
                                end
                                else
                                begin
                                    pass_reg  <= pass_reg + IW'(1);
                                    state_reg <= ST_ROW_RD;
                                end
                            end
                        end
                    end
                end
                ST_OUT_RD:
                begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD:
                begin
                    if (reached_reg[out_idx_reg])
                    begin
                        m_tdata_reg <= OUT_DATA_W'({1'b1, dist_out, VIDX_W'(out_idx_reg)});
                    end
                    else
                    begin
                        m_tdata_reg <= OUT_DATA_W'(VIDX_W'(out_idx_reg));
                    end
                    m_tuser_reg  <= 1'b0;
                    m_tlast_reg  <= out_last;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT:
                begin
                    if (m_axis_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                        if (out_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            out_idx_reg <= out_idx_reg + IW'(1);
                            state_reg   <= ST_OUT_RD;
                        end
                    end
                end
                ST_NEG_WAIT:
                begin
                    if (m_axis_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tlast  = m_tlast_reg;

endmodule
`default_nettype wire
